@@ hw/rtl/kmhc_pkg.sv @@
// kmhc_pkg: shared constants, types and base decode for the k-mer histogram counter
// used by kmhc_tally and kmer_histogram_counter_top; depends on nothing else
`default_nettype none

package kmhc_pkg;

    // k-mer length and counter width
    localparam int KMER_LEN   = 4;
    localparam int COUNT_BITS = 20;

    // table geometry: two bits per base
    localparam int TABLE_BITS = 2 * KMER_LEN;
    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int RUN_BITS   = $clog2(KMER_LEN + 1);

    // port widths of the word fields
    localparam int OPCODE_BITS    = 2;
    localparam int SYMBOL_BITS    = 8;
    localparam int INDEX_BITS     = 8;
    localparam int OUT_COUNT_BITS = 20;
    localparam int ECHO_BITS      = 8;

    // width wide enough to compare the counter against the output ceiling
    localparam int EXT_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

    // opcodes
    localparam logic [OPCODE_BITS-1:0] OP_PUSH    = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_READ    = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_RESTART = 2'd2;

    // base characters
    localparam logic [SYMBOL_BITS-1:0] CHAR_A = 8'h41;
    localparam logic [SYMBOL_BITS-1:0] CHAR_C = 8'h43;
    localparam logic [SYMBOL_BITS-1:0] CHAR_G = 8'h47;
    localparam logic [SYMBOL_BITS-1:0] CHAR_T = 8'h54;

    // decoded base: ok flag and 2-bit lexicographic code
    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } t_base;

    // counter update request from the front end
    typedef struct packed {
        logic                  vld;
        logic                  rd;
        logic [TABLE_BITS-1:0] addr;
    } t_req;

    // status of the read-modify-write stage
    typedef struct packed {
        logic                  vld;
        logic                  rd;
        logic [TABLE_BITS-1:0] addr;
    } t_stage;

    // upper-case A, C, G, T map to 0..3, anything else is not a base
    function automatic t_base base_decode(input logic [SYMBOL_BITS-1:0] ch);
        t_base b;
        b.ok   = 1'b1;
        b.code = 2'd0;
        case (ch)
            CHAR_A: b.code = 2'd0;
            CHAR_C: b.code = 2'd1;
            CHAR_G: b.code = 2'd2;
            CHAR_T: b.code = 2'd3;
            default: b.ok  = 1'b0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/kmhc_tally.sv @@
// kmhc_tally: counter table memory with read-modify-write stage and forwarding
// depends on kmhc_pkg
`default_nettype none

module kmhc_tally (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire kmhc_pkg::t_req                     i_req,
    input  wire                                     i_hold,
    output kmhc_pkg::t_stage                        o_stage,
    output logic [kmhc_pkg::COUNT_BITS-1:0]         o_count
);

    localparam logic [kmhc_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    // counter memory, one read and one write port
    logic [kmhc_pkg::COUNT_BITS-1:0] r_mem [kmhc_pkg::TABLE_SIZE];
    // written-since-reset flags, an unwritten entry reads as zero
    logic [kmhc_pkg::TABLE_SIZE-1:0] r_written;

    kmhc_pkg::t_stage                r_stage;
    logic [kmhc_pkg::COUNT_BITS-1:0] r_rd_data;
    logic                            r_rd_written;

    // last write, forwarded to a read that was issued in the same cycle
    logic                            r_wb_vld;
    logic [kmhc_pkg::TABLE_BITS-1:0] r_wb_addr;
    logic [kmhc_pkg::COUNT_BITS-1:0] r_wb_data;

    logic                            commit;
    logic [kmhc_pkg::COUNT_BITS-1:0] cur;
    logic [kmhc_pkg::COUNT_BITS-1:0] n_value;

    // current counter value with forwarding
    always_comb begin
        if (r_wb_vld && (r_wb_addr == r_stage.addr)) begin
            cur = r_wb_data;
        end else if (r_rd_written) begin
            cur = r_rd_data;
        end else begin
            cur = '0;
        end
    end

    // read clears, push increments with saturation
    always_comb begin
        commit = r_stage.vld && !i_hold;
        if (r_stage.rd) begin
            n_value = '0;
        end else if (cur == COUNT_MAX) begin
            n_value = cur;
        end else begin
            n_value = cur + kmhc_pkg::COUNT_BITS'(1);
        end
    end

    // memory read port, registered
    always_ff @(posedge i_clk) begin
        if (i_req.vld) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_mem[r_stage.addr] <= n_value;
        end
    end

    // stage register, written flags and forwarding valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
            r_written   <= '0;
            r_wb_vld    <= 1'b0;
        end else begin
            if (!i_hold) begin
                r_stage.vld <= i_req.vld;
            end
            if (!i_hold && i_req.vld) begin
                r_stage.rd   <= i_req.rd;
                r_stage.addr <= i_req.addr;
            end
            if (commit) begin
                r_written[r_stage.addr] <= 1'b1;
                r_wb_vld                <= 1'b1;
            end
        end
    end

    // written flag of the staged entry and forwarding payload
    always_ff @(posedge i_clk) begin
        if (!i_hold && i_req.vld) begin
            r_rd_written <= r_written[i_req.addr];
        end
        if (commit) begin
            r_wb_addr <= r_stage.addr;
            r_wb_data <= n_value;
        end
    end

    assign o_stage = r_stage;
    assign o_count = cur;

endmodule

`default_nettype wire

@@ hw/rtl/kmer_histogram_counter_top.sv @@
// kmer_histogram_counter_top: base window tracking, table requests and result register
// depends on kmhc_pkg and kmhc_tally
`default_nettype none

// K-mer histogram counter. Each input word is a push (a raw character byte), a
// read-and-clear of one counter, or a window restart. A, C, G and T extend the
// window; any other byte empties it. Once the window holds KMER_LEN bases every
// push of a base increments that k-mer's saturating counter. The block takes one
// word per clock while not stalled: counters live in a synchronous memory, read
// at the accepting edge and written back from the stage register, with the last
// write forwarded so equal k-mers on consecutive cycles count correctly. A read
// result moves from the table stage into the output register once it is not
// blocked. Input is stalled only when a read result is ready, the output register
// is full and the output is stalled. Reset empties the table at once through
// per-entry written flags, so words are taken as soon as reset is released.
module kmer_histogram_counter_top (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // input channel
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire [kmhc_pkg::OPCODE_BITS-1:0]       i_opcode,
    input  wire [kmhc_pkg::SYMBOL_BITS-1:0]       i_symbol,
    input  wire [kmhc_pkg::INDEX_BITS-1:0]        i_kmer_index,
    // output channel
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic [kmhc_pkg::OUT_COUNT_BITS-1:0]   o_count,
    output logic [kmhc_pkg::ECHO_BITS-1:0]        o_kmer_echo
);

    localparam logic [kmhc_pkg::RUN_BITS-1:0] RUN_FULL = kmhc_pkg::RUN_BITS'(kmhc_pkg::KMER_LEN);
    localparam logic [kmhc_pkg::EXT_BITS-1:0] OUT_MAX  =
        kmhc_pkg::EXT_BITS'({kmhc_pkg::OUT_COUNT_BITS{1'b1}});

    logic [kmhc_pkg::TABLE_BITS-1:0]     r_window;
    logic [kmhc_pkg::TABLE_BITS-1:0]     n_window;
    logic [kmhc_pkg::RUN_BITS-1:0]       r_run;
    logic [kmhc_pkg::RUN_BITS-1:0]       n_run;

    logic                                r_out_valid;
    logic [kmhc_pkg::OUT_COUNT_BITS-1:0] r_out_count;
    logic [kmhc_pkg::ECHO_BITS-1:0]      r_out_echo;

    kmhc_pkg::t_base                     base;
    kmhc_pkg::t_req                      req;
    kmhc_pkg::t_stage                    stage;
    logic [kmhc_pkg::COUNT_BITS-1:0]     cur_count;
    logic [kmhc_pkg::EXT_BITS-1:0]       cur_ext;
    logic [kmhc_pkg::TABLE_BITS-1:0]     shifted;
    logic [kmhc_pkg::RUN_BITS-1:0]       run_inc;
    logic                                blocked;
    logic                                accept;
    logic                                rd_done;

    // a read result that cannot leave holds the table stage and the input
    assign blocked = stage.vld && stage.rd && r_out_valid && i_stall;
    assign o_stall = blocked;
    assign accept  = i_valid && !blocked;
    assign rd_done = stage.vld && stage.rd && !blocked;

    // window and run update
    always_comb begin
        base    = kmhc_pkg::base_decode(i_symbol);
        shifted = kmhc_pkg::TABLE_BITS'({r_window, base.code});
        run_inc = (r_run == RUN_FULL) ? r_run : r_run + kmhc_pkg::RUN_BITS'(1);
        n_window = r_window;
        n_run    = r_run;
        req.vld  = 1'b0;
        req.rd   = 1'b0;
        req.addr = shifted;
        case (i_opcode)
            kmhc_pkg::OP_PUSH: begin
                if (base.ok) begin
                    n_window = shifted;
                    n_run    = run_inc;
                    req.vld  = accept && (run_inc == RUN_FULL);
                end else begin
                    n_window = '0;
                    n_run    = '0;
                end
            end
            kmhc_pkg::OP_READ: begin
                req.vld  = accept;
                req.rd   = 1'b1;
                req.addr = kmhc_pkg::TABLE_BITS'(i_kmer_index);
            end
            kmhc_pkg::OP_RESTART: begin
                n_window = '0;
                n_run    = '0;
            end
            default: begin
            end
        endcase
    end

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_run    <= '0;
        end else if (accept) begin
            r_window <= n_window;
            r_run    <= n_run;
        end
    end

    // counter table
    kmhc_tally u_tally (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_hold  (blocked),
        .o_stage (stage),
        .o_count (cur_count)
    );

    // result word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rd_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result word payload, count clipped to the output width
    assign cur_ext = kmhc_pkg::EXT_BITS'(cur_count);
    always_ff @(posedge i_clk) begin
        if (rd_done) begin
            r_out_count <= (cur_ext > OUT_MAX) ? '1 : cur_ext[kmhc_pkg::OUT_COUNT_BITS-1:0];
            r_out_echo  <= kmhc_pkg::ECHO_BITS'(stage.addr);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_count     = r_out_count;
    assign o_kmer_echo = r_out_echo;

endmodule

`default_nettype wire
